### hw/rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared widths, character and digit codes, the converter-to-emitter handoff type and a BCD digit check.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int FUNC_WIDTH      = 1;
   localparam int VALUE_WIDTH     = 32;
   localparam int CHAR_WIDTH      = 8;
   localparam int DIGIT_WIDTH     = 4;
   localparam int DIGIT_COUNT     = 10;
   localparam int BCD_WIDTH       = DIGIT_WIDTH * DIGIT_COUNT;
   localparam int SHIFT_CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int LEFT_WIDTH      = $clog2(DIGIT_COUNT);

   localparam logic [SHIFT_CNT_WIDTH-1:0] LAST_SHIFT = SHIFT_CNT_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [LEFT_WIDTH-1:0]      LAST_DIGIT = LEFT_WIDTH'(DIGIT_COUNT - 1);

   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_NINE  = 8'd57;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_FIVE = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NINE = 4'd9;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_ADD = 4'd3;

   typedef struct packed {
      logic                 neg;
      logic [BCD_WIDTH-1:0] bcd;
   } b2da_conv_type;

   function automatic logic bcd_ok(input logic [BCD_WIDTH-1:0] bcd);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd[DIGIT_WIDTH*i +: DIGIT_WIDTH] > DIGIT_NINE) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

### hw/rtl/b2da_dabble.sv
// ----------------------------------------------------------------------------
// b2da_dabble
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle, on the magnitude of a negative signed input.
// ----------------------------------------------------------------------------
module b2da_dabble (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [b2da_pkg::FUNC_WIDTH-1:0]  req_func,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0] req_value_bits,
   output logic                             conv_valid,
   input  logic                             conv_stall,
   output b2da_pkg::b2da_conv_type          conv
);
   import b2da_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [VALUE_WIDTH-1:0]     bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]       bcd_ff, bcd_in;
   logic                       neg_ff, neg_in;
   logic [SHIFT_CNT_WIDTH-1:0] count_ff, count_in;
   logic [BCD_WIDTH-1:0]       adj;
   logic                       req_beat;
   logic                       neg_now;

   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd_ff[DIGIT_WIDTH*i +: DIGIT_WIDTH] >= DIGIT_FIVE) begin
            adj[DIGIT_WIDTH*i +: DIGIT_WIDTH] = bcd_ff[DIGIT_WIDTH*i +: DIGIT_WIDTH] + DABBLE_ADD;
         end else begin
            adj[DIGIT_WIDTH*i +: DIGIT_WIDTH] = bcd_ff[DIGIT_WIDTH*i +: DIGIT_WIDTH];
         end
      end
   end

   assign req_stall  = !((state_ff == ST_IDLE) || (state_ff == ST_DONE && !conv_stall));
   assign req_beat   = req_valid && !req_stall;
   assign neg_now    = req_func[0] && req_value_bits[VALUE_WIDTH-1];
   assign conv_valid = (state_ff == ST_DONE);
   assign conv.neg   = neg_ff;
   assign conv.bcd   = bcd_ff;

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      case (state_ff)
         ST_SHIFT: begin
            bcd_in   = {adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in   = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_SHIFT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!conv_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
         end
      endcase
      if (req_beat) begin
         neg_in   = neg_now;
         bin_in   = neg_now ? (~req_value_bits + 1'b1) : req_value_bits;
         bcd_in   = '0;
         count_in = '0;
         state_in = ST_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      neg_ff   <= neg_in;
      count_ff <= count_in;
   end

`ifndef SYNTHESIS
   a_done_bcd: assert property (@(posedge clock) disable iff (reset)
      conv_valid |-> bcd_ok(bcd_ff))
      else $error("converter result holds a digit above nine");
   a_shift_bcd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> bcd_ok(bcd_ff))
      else $error("BCD digit out of range during shifting");
   a_done_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(conv_valid) |-> $past(state_ff == ST_SHIFT && count_ff == LAST_SHIFT))
      else $error("conversion finished without a full shift pass");
`endif

endmodule

### hw/rtl/b2da_emit.sv
// ----------------------------------------------------------------------------
// b2da_emit
// Drops leading zero digits one per cycle, then sends sign and digits as ASCII.
// ----------------------------------------------------------------------------
module b2da_emit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            conv_valid,
   output logic                            conv_stall,
   input  b2da_pkg::b2da_conv_type         conv,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [b2da_pkg::CHAR_WIDTH-1:0] rsp_text_char,
   output logic                            rsp_last_char
);
   import b2da_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type               state_ff, state_in;
   logic [BCD_WIDTH-1:0]    bcd_ff, bcd_in;
   logic                    neg_ff, neg_in;
   logic [LEFT_WIDTH-1:0]   left_ff, left_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]   rsp_text_char_ff, rsp_text_char_in;
   logic                    rsp_last_char_ff, rsp_last_char_in;
   logic [DIGIT_WIDTH-1:0]  top_digit;
   logic                    load;

   assign top_digit     = bcd_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];
   assign load          = !rsp_valid_ff || !rsp_stall;
   assign conv_stall    = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_text_char_ff;
   assign rsp_last_char = rsp_last_char_ff;

   always_comb begin
      state_in         = state_ff;
      bcd_in           = bcd_ff;
      neg_in           = neg_ff;
      left_in          = left_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_text_char_in = rsp_text_char_ff;
      rsp_last_char_in = rsp_last_char_ff;
      case (state_ff)
         ST_IDLE: begin
            if (conv_valid) begin
               bcd_in   = conv.bcd;
               neg_in   = conv.neg;
               left_in  = LAST_DIGIT;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && left_ff != '0) begin
               bcd_in  = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
               left_in = left_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (load) begin
               rsp_valid_in     = 1'b1;
               rsp_text_char_in = CHAR_MINUS;
               rsp_last_char_in = 1'b0;
               state_in         = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (load) begin
               rsp_valid_in     = 1'b1;
               rsp_text_char_in = CHAR_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, top_digit};
               rsp_last_char_in = (left_ff == '0);
               bcd_in           = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
               left_in          = left_ff - 1'b1;
               if (left_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bcd_ff           <= bcd_in;
      neg_ff           <= neg_in;
      left_ff          <= left_in;
      rsp_text_char_ff <= rsp_text_char_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

`ifndef SYNTHESIS
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_char == CHAR_MINUS ||
                     (rsp_text_char >= CHAR_ZERO && rsp_text_char <= CHAR_NINE)))
      else $error("beat carries a character outside sign and digits");
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_char == CHAR_MINUS |-> !rsp_last_char)
      else $error("minus sign marked as last character");
   a_sign_neg: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> neg_ff)
      else $error("sign state entered for a non-negative number");
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> left_ff <= LAST_DIGIT)
      else $error("digit counter out of range");
`endif

endmodule

### hw/rtl/binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// 32-bit integer to decimal ASCII text, one character per result beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat carries req_value_bits and req_func (0 unsigned,
//   1 signed). rsp_ channel: one beat per character, most significant first,
//   a leading '-' for negative signed input, rsp_last_char on the final digit.
//   Zero gives the single character '0'; no leading zeros, no terminator.
// Steps: bit-serial shift and add-3 after the request beat, a handoff to
//   the emitter, leading zeros dropped one digit per cycle, a choice of sign
//   or digit, then one character per cycle while rsp_stall is low.
// Overlap: the bit-serial converter takes a new number as it hands off the
//   last one; the character emitter works on the previous number meanwhile,
//   so without stalls the rate is set by the 32-step shift loop (the emitter
//   finishes each number sooner).
// Reset: synchronous, clears both state machines and the output valid; a
//   number in flight is dropped.
// Stall: rsp_stall holds the current character; the emitter and then the
//   converter back up and req_stall rises.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [b2da_pkg::FUNC_WIDTH-1:0]  req_func,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0] req_value_bits,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]  rsp_text_char,
   output logic                             rsp_last_char
);
   import b2da_pkg::*;

   logic          conv_valid;
   logic          conv_stall;
   b2da_conv_type conv;

   b2da_dabble u_dabble (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value_bits (req_value_bits),
      .conv_valid     (conv_valid),
      .conv_stall     (conv_stall),
      .conv           (conv)
   );

   b2da_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .conv_valid    (conv_valid),
      .conv_stall    (conv_stall),
      .conv          (conv),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

### sim/tb_binary_to_decimal_ascii_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_core
// Self-checking testbench for the 32-bit binary to decimal ASCII converter.
// Directed corner values, then random numbers under three idle/stall mixes
// and a mid-run drain. Each request beat is turned into its expected
// character beats, which are compared in order with the response channel.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_core;
   import b2da_pkg::*;

   localparam logic [FUNC_WIDTH-1:0] FUNC_UNSIGNED = 1'b0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SIGNED   = 1'b1;
   localparam int RADIX       = 10;
   localparam int DRAIN_TAIL  = 60;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] text_char;
      logic                  last_char;
   } char_beat_type;

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [FUNC_WIDTH-1:0]  req_func       = '0;
   logic [VALUE_WIDTH-1:0] req_value_bits = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_text_char;
   logic                   rsp_last_char;

   char_beat_type expected_text[$];
   int            req_idle_pct  = 0;
   int            rsp_stall_pct = 0;
   int            fail_count    = 0;
   int            cycle_count   = 0;

   binary_to_decimal_ascii_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value_bits (req_value_bits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_last_char  (rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("binary_to_decimal_ascii_core regression: fail");
         $finish;
      end
   end

   // expected characters of one number, sign first, most significant digit first
   function automatic void predict_text(input logic [FUNC_WIDTH-1:0] f,
                                        input logic [VALUE_WIDTH-1:0] v);
      logic [VALUE_WIDTH-1:0] mag;
      logic                   neg;
      logic [DIGIT_WIDTH-1:0] digs[DIGIT_COUNT];
      int                     nd;
      neg = (f == FUNC_SIGNED) && v[VALUE_WIDTH-1];
      mag = neg ? (~v + 1'b1) : v;
      nd  = 0;
      do begin
         digs[nd] = DIGIT_WIDTH'(mag % RADIX);
         mag      = mag / RADIX;
         nd++;
      end while (mag != 0);
      if (neg) expected_text.push_back('{CHAR_MINUS, 1'b0});
      for (int i = nd - 1; i >= 0; i--) begin
         expected_text.push_back('{CHAR_ZERO + CHAR_WIDTH'(digs[i]), i == 0});
      end
   endfunction

   // response monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("unexpected beat: text_char %0d last_char %0d",
                      rsp_text_char, rsp_last_char);
               fail_count++;
            end else begin
               if (rsp_text_char !== expected_text[0].text_char) begin
                  $error("text_char mismatch: expected %0d, actual %0d",
                         expected_text[0].text_char, rsp_text_char);
                  fail_count++;
               end
               if (rsp_last_char !== expected_text[0].last_char) begin
                  $error("last_char mismatch: expected %0d, actual %0d",
                         expected_text[0].last_char, rsp_last_char);
                  fail_count++;
               end
               void'(expected_text.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // leaves req_valid high after the beat so back-to-back beats need no toggle
   task automatic send_number(input logic [FUNC_WIDTH-1:0] f,
                              input logic [VALUE_WIDTH-1:0] v);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid      <= 1'b0;
         req_func       <= FUNC_WIDTH'($urandom_range(0, 1));
         req_value_bits <= $urandom;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_value_bits <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_text(f, v);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_value(output logic [FUNC_WIDTH-1:0] f);
      logic [VALUE_WIDTH-1:0] v;
      logic [VALUE_WIDTH-1:0] p;
      f = FUNC_WIDTH'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom >> $urandom_range(0, 31);
         2: begin
            f = FUNC_SIGNED;
            v = -($urandom >> $urandom_range(1, 31));
         end
         default: begin
            // around a power of ten, where the digit count changes
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * RADIX;
            v = p + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) begin
               f = FUNC_SIGNED;
               v = -v;
            end
         end
      endcase
      return v;
   endfunction

   task automatic test_directed_values();
      send_number(FUNC_UNSIGNED, 32'd0);
      send_number(FUNC_SIGNED,   32'd0);
      send_number(FUNC_UNSIGNED, 32'd1);
      send_number(FUNC_SIGNED,   32'd9);
      send_number(FUNC_UNSIGNED, 32'd10);
      send_number(FUNC_SIGNED,   32'd99);
      send_number(FUNC_UNSIGNED, 32'd100);
      send_number(FUNC_UNSIGNED, 32'd999999999);
      send_number(FUNC_UNSIGNED, 32'd1000000000);
      send_number(FUNC_UNSIGNED, 32'hFFFF_FFFF);
      send_number(FUNC_SIGNED,   32'hFFFF_FFFF);
      send_number(FUNC_SIGNED,   32'h8000_0000);
      send_number(FUNC_UNSIGNED, 32'h8000_0000);
      send_number(FUNC_SIGNED,   32'h7FFF_FFFF);
      send_number(FUNC_UNSIGNED, 32'h7FFF_FFFF);
      send_number(FUNC_SIGNED,   32'h8000_0001);
      send_number(FUNC_SIGNED,   -32'sd10);
      send_number(FUNC_SIGNED,   32'hAAAA_AAAA);
      send_number(FUNC_UNSIGNED, 32'h5555_5555);
      send_number(FUNC_UNSIGNED, 32'd4000000000);
   endtask

   task automatic test_random_numbers(input int count);
      logic [FUNC_WIDTH-1:0]  f;
      logic [VALUE_WIDTH-1:0] v;
      repeat (count) begin
         v = random_value(f);
         send_number(f, v);
      end
   endtask

   // sender holds off until every pending character has come out
   task automatic test_drain_pause();
      test_random_numbers(6);
      wait_results_drained();
      send_number(FUNC_SIGNED, 32'h8000_0000);
      send_number(FUNC_UNSIGNED, 32'd0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct  = 33;
      rsp_stall_pct = 58;
      test_directed_values();
      test_random_numbers(130);
      test_drain_pause();
      req_idle_pct  = 58;
      rsp_stall_pct = 33;
      test_random_numbers(130);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_numbers(122);
      wait_results_drained();
      if (fail_count == 0) begin
         $display("binary_to_decimal_ascii_core regression: pass");
      end else begin
         $display("binary_to_decimal_ascii_core regression: fail");
      end
      $finish;
   end

endmodule

### binary_to_decimal_ascii_core.f
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_dabble.sv
hw/rtl/b2da_emit.sv
hw/rtl/binary_to_decimal_ascii_core.sv
sim/tb_binary_to_decimal_ascii_core.sv
